FILE: rtl/core/csjd_pkg.sv
// csjd_pkg: shared types and constants for the channel silence / jamming detector.
// Used by csjd_front, csjd_remdiv, csjd_queue, csjd_back and the top level.
// No dependencies.
package csjd_pkg;

  localparam int NUM_CH      = 3;
  localparam int CH_IDX_W    = 2;
  localparam int OUT_CNT_W   = 16;
  localparam int TICK_W      = 16;
  localparam int STREAK_W    = 8;
  localparam int CHAN_W      = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CHAN_W-1:0]   FIRST_CH         = 6'd37;
  localparam logic [CH_IDX_W-1:0] CH_IDX_NONE      = 2'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX       = 8'hFF;
  localparam logic [TICK_W-1:0]   WINDOW_TICKS_RST = 16'd10;
  localparam logic [STREAK_W-1:0] ALERT_AFTER_RST  = 8'd3;

  // input opcodes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ALERT  = 1'b1;

  // register index (paddr[2])
  localparam logic REG_WINDOW_TICKS = 1'b0;
  localparam logic REG_ALERT_AFTER  = 1'b1;

  // one finished window: six counts plus which channels raise an alert
  typedef struct packed {
    logic [NUM_CH-1:0][OUT_CNT_W-1:0] valid_cnt;
    logic [NUM_CH-1:0][OUT_CNT_W-1:0] invalid_cnt;
    logic [NUM_CH-1:0]                alert;
  } win_t;

  // remainder unit status toward the front
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TICK_W-1:0] rem;
  } rem_stat_t;

endpackage

FILE: rtl/core/csjd_remdiv.sv
// csjd_remdiv: bit-serial restoring remainder, tick_count mod window_ticks.
// One quotient bit per cycle. Depends on csjd_pkg.
module csjd_remdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [csjd_pkg::TICK_W-1:0]  divisor,
  input  logic [csjd_pkg::TICK_W-1:0]  dividend,
  output csjd_pkg::rem_stat_t          stat
);

  logic                        busy_r;
  logic [3:0]                  bit_r;
  logic [csjd_pkg::TICK_W-1:0] div_r;
  logic [csjd_pkg::TICK_W-1:0] num_r;
  logic [csjd_pkg::TICK_W-1:0] rem_r;
  logic [csjd_pkg::TICK_W-1:0] rem_nxt;
  logic [csjd_pkg::TICK_W:0]   shifted;
  logic [csjd_pkg::TICK_W:0]   trial;

  always_comb begin
    shifted = {rem_r, num_r[bit_r]};
    trial   = shifted - {1'b0, div_r};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = trial[csjd_pkg::TICK_W-1:0];
    end else begin
      rem_nxt = shifted[csjd_pkg::TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      bit_r  <= 4'd15;
    end else if (busy_r) begin
      bit_r <= bit_r - 4'd1;
      if (bit_r == 4'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (bit_r == 4'd0);
  assign stat.rem  = rem_nxt;

endmodule

FILE: rtl/core/csjd_front.sv
// csjd_front: accepts items, keeps packet counters, tick/window phase and streaks.
// Pushes one window record per window end. Depends on csjd_pkg.
module csjd_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [1:0]                     in_channel_index,
  input  logic                           in_packet_valid,
  input  logic                           in_is_scanner,
  input  logic                           cfg_hold,
  input  logic [csjd_pkg::TICK_W-1:0]    window_ticks,
  input  logic [csjd_pkg::STREAK_W-1:0]  alert_after,
  input  csjd_pkg::rem_stat_t            rem,
  output logic [csjd_pkg::TICK_W-1:0]    tick_count,
  input  logic                           q_full,
  output logic                           q_push,
  output csjd_pkg::win_t                 q_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0]          vcnt_r   [csjd_pkg::NUM_CH];
  logic [COUNT_WIDTH-1:0]          vcnt_nxt [csjd_pkg::NUM_CH];
  logic [COUNT_WIDTH-1:0]          icnt_r   [csjd_pkg::NUM_CH];
  logic [COUNT_WIDTH-1:0]          icnt_nxt [csjd_pkg::NUM_CH];
  logic [csjd_pkg::STREAK_W-1:0]   streak_r   [csjd_pkg::NUM_CH];
  logic [csjd_pkg::STREAK_W-1:0]   streak_nxt [csjd_pkg::NUM_CH];
  logic [csjd_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [csjd_pkg::TICK_W-1:0]     phase_r, phase_nxt;
  logic                            accept;

  assign in_stall   = cfg_hold || rem.busy || q_full;
  assign accept     = in_valid && !in_stall;
  assign tick_count = tick_r;

  always_comb begin
    logic [csjd_pkg::TICK_W-1:0]   t_inc;
    logic [csjd_pkg::TICK_W-1:0]   ph_inc;
    logic [31:0]                   ext_v;
    logic [31:0]                   ext_i;
    logic [csjd_pkg::STREAK_W-1:0] s_inc;
    logic                          win_end;

    t_inc   = tick_r + 16'd1;
    ph_inc  = phase_r + 16'd1;
    win_end = 1'b0;
    ext_v   = '0;
    ext_i   = '0;
    s_inc   = '0;
    vcnt_nxt   = vcnt_r;
    icnt_nxt   = icnt_r;
    streak_nxt = streak_r;
    tick_nxt   = tick_r;
    phase_nxt  = phase_r;
    q_push     = 1'b0;
    q_data     = '0;

    if (accept) begin
      if (in_opcode == csjd_pkg::OP_PACKET) begin
        if (in_channel_index != csjd_pkg::CH_IDX_NONE) begin
          if (in_packet_valid) begin
            if (vcnt_r[in_channel_index] != CNT_MAX) begin
              vcnt_nxt[in_channel_index] = vcnt_r[in_channel_index] + COUNT_WIDTH'(1);
            end
          end else begin
            if (icnt_r[in_channel_index] != CNT_MAX) begin
              icnt_nxt[in_channel_index] = icnt_r[in_channel_index] + COUNT_WIDTH'(1);
            end
          end
        end
      end else if (!in_is_scanner) begin
        for (int i = 0; i < csjd_pkg::NUM_CH; i++) begin
          vcnt_nxt[i] = '0;
          icnt_nxt[i] = '0;
        end
        tick_nxt  = '0;
        phase_nxt = '0;
      end else begin
        tick_nxt = t_inc;
        // phase tracks tick_count mod window_ticks; the wrap to zero is a multiple too
        if (t_inc == '0 || ph_inc == window_ticks) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = ph_inc;
        end
        win_end = (t_inc != '0) && (window_ticks != '0) && (ph_inc == window_ticks);
        if (win_end) begin
          q_push = 1'b1;
          for (int i = 0; i < csjd_pkg::NUM_CH; i++) begin
            ext_v = 32'(vcnt_r[i]);
            ext_i = 32'(icnt_r[i]);
            q_data.valid_cnt[i]   = ext_v[csjd_pkg::OUT_CNT_W-1:0];
            q_data.invalid_cnt[i] = ext_i[csjd_pkg::OUT_CNT_W-1:0];
            if (vcnt_r[i] == '0) begin
              s_inc = (streak_r[i] == csjd_pkg::STREAK_MAX) ? streak_r[i]
                                                           : streak_r[i] + 8'd1;
              streak_nxt[i]   = s_inc;
              q_data.alert[i] = (s_inc > alert_after);
            end else begin
              streak_nxt[i] = '0;
            end
            vcnt_nxt[i] = '0;
            icnt_nxt[i] = '0;
          end
        end
      end
    end

    if (rem.done) begin
      phase_nxt = rem.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < csjd_pkg::NUM_CH; i++) begin
        vcnt_r[i]   <= '0;
        icnt_r[i]   <= '0;
        streak_r[i] <= '0;
      end
      tick_r  <= '0;
      phase_r <= '0;
    end else begin
      vcnt_r   <= vcnt_nxt;
      icnt_r   <= icnt_nxt;
      streak_r <= streak_nxt;
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

FILE: rtl/core/csjd_queue.sv
// csjd_queue: short FIFO of window records between front and back.
// Register based, QUEUE_DEPTH entries. Depends on csjd_pkg.
module csjd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csjd_pkg::win_t push_data,
  input  logic           pop,
  output csjd_pkg::win_t head,
  output logic           empty,
  output logic           full
);

  csjd_pkg::win_t                mem_r [csjd_pkg::QUEUE_DEPTH];
  logic [csjd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [csjd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [csjd_pkg::QCNT_W-1:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == csjd_pkg::QCNT_W'(csjd_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + csjd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + csjd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + csjd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - csjd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/csjd_back.sv
// csjd_back: turns each window record into a report followed by its alerts.
// Drives the registered result channel. Depends on csjd_pkg.
module csjd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csjd_pkg::win_t                head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_valid_count_a,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_valid_count_b,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_valid_count_c,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_invalid_count_a,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_invalid_count_b,
  output logic [csjd_pkg::OUT_CNT_W-1:0] out_invalid_count_c,
  output logic [csjd_pkg::CHAN_W-1:0]   out_alert_channel,
  output logic                          out_last_result
);

  logic                           out_valid_r;
  logic                           kind_r;
  logic [csjd_pkg::NUM_CH-1:0][csjd_pkg::OUT_CNT_W-1:0] vcnt_r;
  logic [csjd_pkg::NUM_CH-1:0][csjd_pkg::OUT_CNT_W-1:0] icnt_r;
  logic [csjd_pkg::CHAN_W-1:0]    chan_r;
  logic                           last_r;
  logic                           rep_sent_r;
  logic [csjd_pkg::NUM_CH-1:0]    done_r;

  logic [csjd_pkg::NUM_CH-1:0]    remain;
  logic [csjd_pkg::NUM_CH-1:0]    sel;
  logic [csjd_pkg::CHAN_W-1:0]    sel_chan;
  logic                           nxt_kind;
  logic                           nxt_last;
  logic                           load;

  always_comb begin
    remain = head.alert & ~done_r;
    if (remain[0]) begin
      sel      = 3'b001;
      sel_chan = csjd_pkg::FIRST_CH;
    end else if (remain[1]) begin
      sel      = 3'b010;
      sel_chan = csjd_pkg::FIRST_CH + 6'd1;
    end else begin
      sel      = 3'b100;
      sel_chan = csjd_pkg::FIRST_CH + 6'd2;
    end
    if (!rep_sent_r) begin
      nxt_kind = csjd_pkg::KIND_REPORT;
      nxt_last = (head.alert == '0);
    end else begin
      nxt_kind = csjd_pkg::KIND_ALERT;
      nxt_last = ((remain & ~sel) == '0);
    end
  end

  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load && nxt_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rep_sent_r  <= 1'b0;
      done_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      if (nxt_last) begin
        rep_sent_r <= 1'b0;
        done_r     <= '0;
      end else if (!rep_sent_r) begin
        rep_sent_r <= 1'b1;
      end else begin
        done_r <= done_r | sel;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= nxt_kind;
      last_r <= nxt_last;
      if (nxt_kind == csjd_pkg::KIND_REPORT) begin
        vcnt_r <= head.valid_cnt;
        icnt_r <= head.invalid_cnt;
        chan_r <= '0;
      end else begin
        vcnt_r <= '0;
        icnt_r <= '0;
        chan_r <= sel_chan;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_valid_count_a   = vcnt_r[0];
  assign out_valid_count_b   = vcnt_r[1];
  assign out_valid_count_c   = vcnt_r[2];
  assign out_invalid_count_a = icnt_r[0];
  assign out_invalid_count_b = icnt_r[1];
  assign out_invalid_count_c = icnt_r[2];
  assign out_alert_channel   = chan_r;
  assign out_last_result     = last_r;

endmodule

FILE: rtl/core/channel_silence_jamming_detector_unit.sv
// channel_silence_jamming_detector_unit: top level, config registers and wiring.
// Depends on csjd_pkg, csjd_remdiv, csjd_front, csjd_queue, csjd_back.
//
// Usage:
//   Input channel (in_valid/in_stall): packet items (opcode 0) bump the valid or
//   invalid counter of a channel; tick items (opcode 1) with in_is_scanner advance
//   the window, others restart it. One item is taken per cycle while in_stall is low.
//   Result channel (out_valid/out_stall): at each window end one report with
//   the six counts, then one alert per jammed channel in order 37, 38, 39;
//   last_result marks the final result of that tick.
//   A window-ending tick's record passes through the window queue into the result
//   registers; results then follow one per cycle while the receiver does not stall.
//   A four-entry window queue sits between intake and result output; intake
//   also stalls while that queue holds four windows.
//   Writing window_ticks starts a bit-serial remainder of the tick counter;
//   input stalls during the write and while the remainder runs.
//   Reset: window_ticks 10, alert_after 3, all counts, streaks and the tick
//   counter zero; no results pending.
//   APB: window_ticks at 0x0, alert_after at 0x4; pready is always high.
module channel_silence_jamming_detector_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [1:0]                    in_channel_index,
  input  logic                          in_packet_valid,
  input  logic                          in_is_scanner,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [15:0]                   out_valid_count_a,
  output logic [15:0]                   out_valid_count_b,
  output logic [15:0]                   out_valid_count_c,
  output logic [15:0]                   out_invalid_count_a,
  output logic [15:0]                   out_invalid_count_b,
  output logic [15:0]                   out_invalid_count_c,
  output logic [5:0]                    out_alert_channel,
  output logic                          out_last_result,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [csjd_pkg::TICK_W-1:0]   window_ticks_r;
  logic [csjd_pkg::STREAK_W-1:0] alert_after_r;
  logic                          cfg_wr;
  logic                          rem_start;
  logic [csjd_pkg::TICK_W-1:0]   tick_count;
  csjd_pkg::rem_stat_t           rem_stat;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_empty;
  logic                          q_full;
  csjd_pkg::win_t                q_in;
  csjd_pkg::win_t                q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign rem_start  = cfg_wr && (cfg_paddr[2] == csjd_pkg::REG_WINDOW_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= csjd_pkg::WINDOW_TICKS_RST;
      alert_after_r  <= csjd_pkg::ALERT_AFTER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        csjd_pkg::REG_WINDOW_TICKS: window_ticks_r <= cfg_pwdata[15:0];
        csjd_pkg::REG_ALERT_AFTER:  alert_after_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      csjd_pkg::REG_WINDOW_TICKS: cfg_prdata = {16'h0000, window_ticks_r};
      csjd_pkg::REG_ALERT_AFTER:  cfg_prdata = {24'h000000, alert_after_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  csjd_remdiv u_remdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .divisor  (cfg_pwdata[15:0]),
    .dividend (tick_count),
    .stat     (rem_stat)
  );

  csjd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_channel_index (in_channel_index),
    .in_packet_valid  (in_packet_valid),
    .in_is_scanner    (in_is_scanner),
    .cfg_hold         (cfg_wr),
    .window_ticks     (window_ticks_r),
    .alert_after      (alert_after_r),
    .rem              (rem_stat),
    .tick_count       (tick_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  csjd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  csjd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_valid_count_a   (out_valid_count_a),
    .out_valid_count_b   (out_valid_count_b),
    .out_valid_count_c   (out_valid_count_c),
    .out_invalid_count_a (out_invalid_count_a),
    .out_invalid_count_b (out_invalid_count_b),
    .out_invalid_count_c (out_invalid_count_c),
    .out_alert_channel   (out_alert_channel),
    .out_last_result     (out_last_result)
  );

endmodule
